### sv/eac_pkg.sv
// Shared constants, types and state encoding for the event alignment checker.
package eac_pkg;

  localparam int MAX_MODULES = 16;
  localparam int SLOT_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int COUNT_W = $clog2(MAX_MODULES + 1);
  localparam int ID_W = 8;
  localparam int NUM_W = 32;
  localparam int TIME_W = 48;
  localparam int OUT_SLOT_W = 4;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 3'd0,
    STAT_NULL = 3'd1,
    STAT_HDR  = 3'd2,
    STAT_MISS = 3'd3,
    STAT_LATE = 3'd4
  } status_t;

  typedef enum logic {
    S_LOAD,
    S_EMIT
  } state_t;

  // One stored module header.
  typedef struct packed {
    logic              bad;
    logic              nul;
    logic [NUM_W-1:0]  number;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  // Event-wide facts that the status stage needs for every slot.
  typedef struct packed {
    logic              single;
    logic              any_null;
    logic              missed;
    logic [NUM_W-1:0]  least_number;
    logic [TIME_W-1:0] least_time;
  } evt_ctx_t;

  // Read request travelling alongside the memory read data.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } rd_tag_t;

endpackage

### sv/eac_store.sv
// Header store: one write port, one read port with a registered read.
module eac_store
  import eac_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [MAX_MODULES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/eac_status.sv
// Status decision for one stored header and the result output register.
module eac_status
  import eac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  rd_tag_t               tag,
  input  entry_t                entry,
  input  evt_ctx_t              ctx,
  output logic                  strobe,
  output logic [OUT_SLOT_W-1:0] module_slot,
  output logic [STATUS_W-1:0]   status,
  output logic                  last_status
);

  status_t stat_next;

  always_comb begin
    stat_next = STAT_OK;
    priority if (ctx.single) begin
      if (entry.bad) stat_next = STAT_HDR;
    end else if (ctx.any_null) begin
      if (entry.nul) stat_next = STAT_NULL;
    end else begin
      if (entry.bad) stat_next = STAT_HDR;
      if (entry.number > ctx.least_number) begin
        stat_next = STAT_MISS;
      end else if (!ctx.missed && !entry.bad && entry.tstamp > ctx.least_time) begin
        stat_next = STAT_LATE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      module_slot <= OUT_SLOT_W'(tag.slot);
      status      <= stat_next;
      last_status <= tag.last;
    end
  end

endmodule

### sv/event_alignment_checker.sv
// Top level of the event alignment checker: load control, event minima and readout.
//
// Headers are taken one per cycle while busy is low; each is written to the next
// slot of the header memory and the event minima are updated as it goes by. A
// header marked last raises busy and starts the readout, which walks the stored
// slots one per cycle through the registered memory read and a status register.
// For an event of n stored modules busy stays high until the last slot's read
// data has reached the status stage, and the n results appear with strobe on
// consecutive cycles, the final one as busy falls. Results cannot be held
// off, so they must be taken in the cycle they are shown. Headers beyond 16 in
// one event are dropped, but a last mark on them still triggers the readout.
module event_alignment_checker
  import eac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ID_W-1:0]       module_id,
  input  logic                  header_bad,
  input  logic [NUM_W-1:0]      trigger_number,
  input  logic [TIME_W-1:0]     trigger_time,
  input  logic                  last_module,
  output logic                  strobe,
  output logic [OUT_SLOT_W-1:0] module_slot,
  output logic [STATUS_W-1:0]   status,
  output logic                  last_status
);

  state_t             state, state_next;
  logic [COUNT_W-1:0] module_count;
  logic [COUNT_W-1:0] issue_cnt;
  logic               issued_all;
  logic [NUM_W-1:0]   least_number;
  logic [NUM_W-1:0]   most_number;
  logic [TIME_W-1:0]  least_time;
  logic               any_null;
  rd_tag_t            tag;

  logic     accept;
  logic     store_en;
  logic     issue;
  logic     issue_last;
  logic     done;
  entry_t   wdata;
  entry_t   rdata;
  evt_ctx_t ctx;

  assign accept     = start && !busy;
  assign store_en   = accept && (module_count < COUNT_W'(MAX_MODULES));
  assign issue_last = (issue_cnt + COUNT_W'(1)) == module_count;
  assign done       = tag.valid && tag.last;

  always_comb begin
    wdata.bad    = header_bad;
    wdata.nul    = (module_id == '0);
    wdata.number = trigger_number;
    wdata.tstamp = trigger_time;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: if (accept && last_module) state_next = S_EMIT;
      S_EMIT: if (done) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    unique case (state)
      S_LOAD: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
      S_EMIT: begin
        busy  = 1'b1;
        issue = !issued_all;
      end
      default: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      module_count <= '0;
      least_number <= '1;
      most_number  <= '0;
      least_time   <= '1;
      any_null     <= 1'b0;
      issue_cnt    <= '0;
      issued_all   <= 1'b0;
      tag          <= '0;
    end else begin
      state     <= state_next;
      tag.valid <= issue;
      tag.last  <= issue && issue_last;
      tag.slot  <= issue_cnt[SLOT_W-1:0];
      if (store_en) begin
        module_count <= module_count + COUNT_W'(1);
        if (wdata.nul) any_null <= 1'b1;
        if (trigger_number > most_number) most_number <= trigger_number;
        if (!header_bad) begin
          if (trigger_number < least_number) least_number <= trigger_number;
          if (trigger_time < least_time) least_time <= trigger_time;
        end
      end
      if (accept && last_module) begin
        issue_cnt  <= '0;
        issued_all <= 1'b0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + COUNT_W'(1);
        if (issue_last) issued_all <= 1'b1;
      end
      // The final slot is being decided this cycle; the event can be cleared.
      if (done) begin
        module_count <= '0;
        least_number <= '1;
        most_number  <= '0;
        least_time   <= '1;
        any_null     <= 1'b0;
      end
    end
  end

  // A module is missed only if some stored number exceeds the unflagged minimum,
  // which is the same as the largest stored number exceeding it.
  always_comb begin
    ctx.single       = (module_count == COUNT_W'(1));
    ctx.any_null     = any_null;
    ctx.missed       = most_number > least_number;
    ctx.least_number = least_number;
    ctx.least_time   = least_time;
  end

  eac_store u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (module_count[SLOT_W-1:0]),
    .wdata (wdata),
    .re    (issue),
    .raddr (issue_cnt[SLOT_W-1:0]),
    .rdata (rdata)
  );

  eac_status u_status (
    .clk         (clk),
    .rst         (rst),
    .tag         (tag),
    .entry       (rdata),
    .ctx         (ctx),
    .strobe      (strobe),
    .module_slot (module_slot),
    .status      (status),
    .last_status (last_status)
  );

endmodule
